[hdl/b64d_pkg.sv]
// Shared types and constants for the base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  // Alphabet value offsets
  localparam logic [5:0] LowerOffset = 6'd26;
  localparam logic [5:0] DigitOffset = 6'd52;
  localparam logic [5:0] PlusValue   = 6'd62;
  localparam logic [5:0] SlashValue  = 6'd63;

  typedef enum logic [1:0] {
    CLS_DATA = 2'd0,
    CLS_SKIP = 2'd1,
    CLS_BAD  = 2'd2
  } b64d_kind_e;

  typedef struct packed {
    b64d_kind_e kind;
    logic [5:0] value;
  } b64d_class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       malformed;
    logic       message_end;
  } b64d_out_t;

endpackage

`default_nettype wire

[hdl/b64d_classify.sv]
// Character classifier: maps a raw byte to a 6-bit value, skip or illegal.
`timescale 1ns / 1ps
`default_nettype none

module b64d_classify (
  input  logic [7:0]            char_i,
  output b64d_pkg::b64d_class_t cls_o
);
  import b64d_pkg::*;

  always_comb begin
    cls_o.kind  = CLS_BAD;
    cls_o.value = '0;
    unique case (char_i) inside
      [8'h41:8'h5a]: begin  // A-Z
        cls_o.kind  = CLS_DATA;
        cls_o.value = 6'(char_i - 8'h41);
      end
      [8'h61:8'h7a]: begin  // a-z
        cls_o.kind  = CLS_DATA;
        cls_o.value = 6'(char_i - 8'h61) + LowerOffset;
      end
      [8'h30:8'h39]: begin  // 0-9
        cls_o.kind  = CLS_DATA;
        cls_o.value = 6'(char_i - 8'h30) + DigitOffset;
      end
      8'h2b: begin  // '+'
        cls_o.kind  = CLS_DATA;
        cls_o.value = PlusValue;
      end
      8'h2f: begin  // '/'
        cls_o.kind  = CLS_DATA;
        cls_o.value = SlashValue;
      end
      8'h3d, 8'h0d, 8'h0a, 8'h20: begin  // '=', CR, LF, space
        cls_o.kind = CLS_SKIP;
      end
      default: begin
        cls_o.kind = CLS_BAD;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/b64d_accum.sv]
// Bit accumulator, sticky error flag and result register.
`timescale 1ns / 1ps
`default_nettype none

module b64d_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  b64d_pkg::b64d_class_t cls_i,
  input  logic                  fin_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output b64d_pkg::b64d_out_t   out_data_o
);
  import b64d_pkg::*;

  logic [5:0]  bits_q, bits_d;
  logic [2:0]  count_q, count_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  b64d_out_t   out_q, out_d;

  logic [3:0]  cnt_sum;
  logic [3:0]  cnt_rem;
  logic [11:0] acc;
  logic [11:0] acc_shift;
  logic [5:0]  keep_mask;
  logic        emit;
  logic        err_now;

  assign room_o      = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cnt_sum   = {1'b0, count_q} + 4'd6;
    acc       = {bits_q, cls_i.value};
    emit      = cnt_sum >= 4'd8;
    cnt_rem   = emit ? (cnt_sum - 4'd8) : cnt_sum;
    acc_shift = acc >> cnt_rem;
    for (int i = 0; i < 6; i++) begin
      keep_mask[i] = (4'(i) < cnt_rem);
    end
    err_now = err_q || (cls_i.kind == CLS_BAD);

    bits_d  = bits_q;
    count_d = count_q;
    err_d   = err_now;
    out_d   = '0;
    if ((cls_i.kind == CLS_DATA) && !err_q) begin
      bits_d  = acc[5:0] & keep_mask;
      count_d = cnt_rem[2:0];
      if (emit) begin
        out_d.data_byte  = acc_shift[7:0];
        out_d.byte_valid = 1'b1;
      end
    end
    out_d.message_end = fin_i;
    out_d.malformed   = fin_i && err_now;
    if (fin_i) begin
      bits_d  = '0;
      count_d = '0;
      err_d   = 1'b0;
    end

    out_valid_d = take_i || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_i) begin
        bits_q  <= bits_d;
        count_q <= count_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      out_q <= out_d;
    end
  end

  // only an even number of bits can ever be pending
  a_count_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !count_q[0]) else $error("odd pending bit count");

  // end of message clears the whole state
  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && fin_i |=> !err_q && (count_q == 3'd0) && (bits_q == 6'd0))
    else $error("state not cleared after final character");

  // a delivered byte and an error report never share a result
  a_valid_not_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.byte_valid |-> !out_q.malformed)
    else $error("byte emitted on malformed message end");

  a_bad_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.malformed |-> out_q.message_end)
    else $error("malformed reported before message end");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.byte_valid |-> (out_q.data_byte == 8'd0))
    else $error("data byte not zero without a byte");

endmodule

`default_nettype wire

[hdl/base64_stream_decoder_unit.sv]
// Top level of the streaming base64 decoder.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one raw
//   character per transfer plus a flag for the last character of a message.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one result per character: a decoded byte with its valid flag, the
//   message-end copy and, on the final character, the malformed flag.
//   Illegal characters poison the rest of the message; bytes stop and the
//   consumer sees malformed=1 on the last result.
// Path: input register, then the accumulator and result register; while the
//   result register is full a character waits in the input register.
// Throughput: one character per cycle unless out_ready_i is low; the
//   accumulator update is a single short add, shift and mask between the
//   input and result registers.
// Reset: rst_ni clears the accumulator, the error flag and both valid bits;
//   the block is ready as soon as the input valid bit is cleared.
// Stall: with out_ready_i low the result is held, the input register fills
//   and in_ready_o drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64d_pkg::b64d_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64d_pkg::b64d_out_t out_data_o
);
  import b64d_pkg::*;

  // input register stage
  logic        s1_valid_q, s1_valid_d;
  b64d_in_t    s1_q;
  logic        room;       // result register can take an item
  logic        take;       // stage-one item moves on
  b64d_class_t cls;

  assign take       = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || room;

  always_comb begin
    s1_valid_d = (s1_valid_q && !room) || (in_valid_i && in_ready_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  b64d_classify u_classify (
    .char_i (s1_q.char_code),
    .cls_o  (cls)
  );

  b64d_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .cls_i       (cls),
    .fin_i       (s1_q.final_char),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
